[hdl/blph_pkg.sv]
// Package: sizes, codes and hash/remainder step functions for the probe hash table.
`timescale 1ns / 1ps
package blph_pkg;

  localparam int NUM_BLOCKS        = 256;
  localparam int SLOTS_PER_BLOCK_N = 4;
  localparam int TOTAL_SLOTS       = NUM_BLOCKS * SLOTS_PER_BLOCK_N;
  localparam int BLK_W             = $clog2(NUM_BLOCKS);
  localparam int SLOT_W            = $clog2(SLOTS_PER_BLOCK_N);
  localparam int IDX_W             = BLK_W + SLOT_W;
  localparam int NB_W              = 9;
  localparam int CNT_W             = 11;
  localparam int SEEN_W            = CNT_W + 1;
  localparam int KEY_W             = 64;
  localparam int VAL_W             = 64;
  localparam int NIB_W             = 4;
  localparam int HASH_STEPS        = KEY_W / 8;
  localparam int MOD_STEPS         = KEY_W / NIB_W;
  localparam int STEP_W            = $clog2(MOD_STEPS);

  localparam logic [CNT_W-1:0] COUNT_MAX   = {CNT_W{1'b1}};
  localparam logic [KEY_W-1:0] FNV_OFFSET  = 64'hcbf29ce484222325;
  localparam logic [NB_W-1:0]  BLOCKS_MIN  = NB_W'(2);
  localparam logic [NB_W-1:0]  BLOCKS_MAX  = NB_W'(NUM_BLOCKS);

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_DUP    = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // One FNV-1a byte step; the prime 2^40 + 0x1b3 is applied as a shift sum.
  function automatic logic [KEY_W-1:0] fnv_step(input logic [KEY_W-1:0] h,
                                                input logic [7:0] b);
    logic [KEY_W-1:0] x;
    x = h ^ {{(KEY_W-8){1'b0}}, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  // Four restoring remainder steps on one nibble of the dividend.
  function automatic logic [NB_W-1:0] mod_step(input logic [NB_W-1:0] r,
                                               input logic [NIB_W-1:0] nib,
                                               input logic [NB_W-1:0] n);
    logic [NB_W-1:0] t;
    t = r;
    for (int i = NIB_W - 1; i >= 0; i--) begin
      t = {t[NB_W-2:0], nib[i]};
      if (t >= n) begin
        t = t - n;
      end
    end
    return t;
  endfunction

endpackage

[hdl/bucketized_linear_probe_hash_table.sv]
// Top level: key-value engine over blocks of slots with linear probing across blocks.
//
// Request channel: op_i, key_i and value_i transfer when start is high and busy is low.
// Each request gives one result: done_o is high for exactly one cycle with status_o and
// found_value_o; the receiver cannot stall it. busy stays high until that cycle.
// Configuration: cfg_data_i (blocks_in_use) transfers on cfg_valid_i && cfg_ready_o; the
// value is sampled when a request starts.
// After reset a clearing pass over the 256 block rows (used bits, home counts) runs with
// busy high.
// One shared FNV-1a step unit and a radix-16 remainder unit give the home block. Each probed
// block reads its used bits and each used slot its stored key; find and delete run the same
// hash unit again for every stored key of another key along the chain, while insert passes
// used slots without hashing them. Delete ends by moving the last chain entry.
`timescale 1ns / 1ps
module bucketized_linear_probe_hash_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   op_i,
  input  logic [blph_pkg::KEY_W-1:0]   key_i,
  input  logic [blph_pkg::VAL_W-1:0]   value_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [blph_pkg::VAL_W-1:0]   found_value_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [blph_pkg::NB_W-1:0]    cfg_data_i
);
  import blph_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_MOD, S_CNT, S_CNT2, S_ROW, S_ROW2,
    S_SLOT, S_KEY, S_BLKEND, S_DEL1, S_DEL2
  } state_e;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS_PER_BLOCK_N - 1);

  state_e                  state_q, state_d;
  logic [NB_W-1:0]         blocks_q;
  op_e                     op_q, op_d;
  logic [KEY_W-1:0]        key_q, key_d;
  logic [VAL_W-1:0]        val_q, val_d;
  logic [NB_W-1:0]         n_q, n_d;
  logic [KEY_W-1:0]        hk_q, hk_d;
  logic [KEY_W-1:0]        h_q, h_d;
  logic [NB_W-1:0]         rem_q, rem_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic                    slot_hash_q, slot_hash_d;
  logic [BLK_W-1:0]        home_q, home_d;
  logic [CNT_W-1:0]        need_q, need_d;
  logic [SEEN_W-1:0]       seen_q, seen_d;
  logic [BLK_W-1:0]        blk_q, blk_d;
  logic [NB_W-1:0]         walked_q, walked_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic [SLOTS_PER_BLOCK_N-1:0] row_q, row_d;
  logic                    found_q, found_d;
  logic [IDX_W-1:0]        key_at_q, key_at_d;
  logic [IDX_W-1:0]        last_at_q, last_at_d;
  logic                    last_ok_q, last_ok_d;
  logic [CNT_W-1:0]        stored_q, stored_d;
  logic [BLK_W-1:0]        clr_q, clr_d;
  logic                    done_q, done_d;
  status_e                 status_q, status_d;
  logic [VAL_W-1:0]        fv_q, fv_d;

  logic [KEY_W-1:0]             kv_key_mem [TOTAL_SLOTS];
  logic [VAL_W-1:0]             kv_val_mem [TOTAL_SLOTS];
  logic [SLOTS_PER_BLOCK_N-1:0] used_mem   [NUM_BLOCKS];
  logic [CNT_W-1:0]             cnt_mem    [NUM_BLOCKS];

  logic                         kv_we;
  logic [IDX_W-1:0]             kv_wa, kv_ra;
  logic [KEY_W-1:0]             kv_wkey, key_rd_q;
  logic [VAL_W-1:0]             kv_wval, val_rd_q;
  logic                         used_we;
  logic [BLK_W-1:0]             used_wa, used_ra;
  logic [SLOTS_PER_BLOCK_N-1:0] used_wd, used_rd_q;
  logic                         cnt_we;
  logic [BLK_W-1:0]             cnt_wa;
  logic [CNT_W-1:0]             cnt_wd, cnt_rd_q;

  logic [IDX_W-1:0]        cur_idx, del_idx;
  logic [NB_W-1:0]         n_eff;
  logic                    del_phase, adv, hit, fin;
  status_e                 fin_status;
  logic [VAL_W-1:0]        fin_value;

  assign cur_idx   = {blk_q, slot_q};
  assign del_idx   = last_ok_q ? last_at_q : key_at_q;
  assign del_phase = (state_q == S_DEL1) || (state_q == S_DEL2);
  assign kv_ra     = del_phase ? last_at_q : cur_idx;
  assign used_ra   = del_phase ? del_idx[IDX_W-1:SLOT_W] : blk_q;

  assign n_eff = (blocks_q < BLOCKS_MIN) ? BLOCKS_MIN :
                 ((blocks_q > BLOCKS_MAX) ? BLOCKS_MAX : blocks_q);

  assign busy          = (state_q != S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_value_o = fv_q;

  always_ff @(posedge clk_i) begin
    if (kv_we) begin
      kv_key_mem[kv_wa] <= kv_wkey;
      kv_val_mem[kv_wa] <= kv_wval;
    end
    key_rd_q <= kv_key_mem[kv_ra];
    val_rd_q <= kv_val_mem[kv_ra];
  end

  always_ff @(posedge clk_i) begin
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
    end
    used_rd_q <= used_mem[used_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd_q <= cnt_mem[home_q];
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    val_d       = val_q;
    n_d         = n_q;
    hk_d        = hk_q;
    h_d         = h_q;
    rem_d       = rem_q;
    step_d      = step_q;
    slot_hash_d = slot_hash_q;
    home_d      = home_q;
    need_d      = need_q;
    seen_d      = seen_q;
    blk_d       = blk_q;
    walked_d    = walked_q;
    slot_d      = slot_q;
    row_d       = row_q;
    found_d     = found_q;
    key_at_d    = key_at_q;
    last_at_d   = last_at_q;
    last_ok_d   = last_ok_q;
    stored_d    = stored_q;
    clr_d       = clr_q;
    done_d      = 1'b0;
    status_d    = status_q;
    fv_d        = fv_q;
    kv_we       = 1'b0;
    kv_wa       = cur_idx;
    kv_wkey     = key_q;
    kv_wval     = val_q;
    used_we     = 1'b0;
    used_wa     = blk_q;
    used_wd     = row_q;
    cnt_we      = 1'b0;
    cnt_wa      = home_q;
    cnt_wd      = need_q;
    adv         = 1'b0;
    hit         = 1'b0;
    fin         = 1'b0;
    fin_status  = ST_ABSENT;
    fin_value   = '0;

    case (state_q)
      S_CLEAR: begin
        used_we = 1'b1;
        used_wa = clr_q;
        used_wd = '0;
        cnt_we  = 1'b1;
        cnt_wa  = clr_q;
        cnt_wd  = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == BLK_W'(NUM_BLOCKS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_d        = op_e'(op_i);
          key_d       = key_i;
          val_d       = value_i;
          n_d         = n_eff;
          hk_d        = key_i;
          h_d         = FNV_OFFSET;
          step_d      = '0;
          slot_hash_d = 1'b0;
          if (op_e'(op_i) == OP_NONE ||
              (op_e'(op_i) == OP_DELETE && stored_q == '0)) begin
            fin = 1'b1;
          end else begin
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        h_d    = fnv_step(h_q, hk_q[7:0]);
        hk_d   = hk_q >> 8;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(HASH_STEPS - 1)) begin
          step_d  = '0;
          rem_d   = '0;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        rem_d  = mod_step(rem_q, h_q[KEY_W-1 -: NIB_W], n_q);
        h_d    = h_q << NIB_W;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(MOD_STEPS - 1)) begin
          if (slot_hash_q) begin
            hit = (rem_d[BLK_W-1:0] == home_q);
            adv = 1'b1;
          end else begin
            home_d  = rem_d[BLK_W-1:0];
            state_d = S_CNT;
          end
        end
      end
      S_CNT: begin
        state_d = S_CNT2;
      end
      S_CNT2: begin
        need_d    = cnt_rd_q;
        blk_d     = home_q;
        walked_d  = '0;
        seen_d    = '0;
        found_d   = 1'b0;
        last_ok_d = 1'b0;
        if (op_q == OP_INSERT) begin
          if (cnt_rd_q >= COUNT_MAX) begin
            fin        = 1'b1;
            fin_status = ST_FULL;
          end else begin
            state_d = S_ROW;
          end
        end else if (cnt_rd_q == '0) begin
          fin = 1'b1;
        end else begin
          state_d = S_ROW;
        end
      end
      S_ROW: begin
        state_d = S_ROW2;
      end
      S_ROW2: begin
        row_d   = used_rd_q;
        slot_d  = '0;
        state_d = S_SLOT;
      end
      S_SLOT: begin
        if (!row_q[slot_q]) begin
          if (op_q == OP_INSERT) begin
            kv_we    = 1'b1;
            used_we  = 1'b1;
            used_wd  = row_q | (SLOTS_PER_BLOCK_N'(1) << slot_q);
            cnt_we   = 1'b1;
            cnt_wd   = need_q + 1'b1;
            if (stored_q != COUNT_MAX) begin
              stored_d = stored_q + 1'b1;
            end
            fin        = 1'b1;
            fin_status = ST_OK;
          end else begin
            adv = 1'b1;
          end
        end else begin
          state_d = S_KEY;
        end
      end
      S_KEY: begin
        if (key_rd_q == key_q) begin
          case (op_q)
            OP_INSERT: begin
              fin        = 1'b1;
              fin_status = ST_DUP;
            end
            OP_FIND: begin
              fin        = 1'b1;
              fin_status = ST_OK;
              fin_value  = val_rd_q;
            end
            default: begin
              found_d  = 1'b1;
              key_at_d = cur_idx;
              hit      = 1'b1;
              adv      = 1'b1;
            end
          endcase
        end else if (op_q == OP_INSERT) begin
          adv = 1'b1;
        end else begin
          hk_d        = key_rd_q;
          h_d         = FNV_OFFSET;
          step_d      = '0;
          slot_hash_d = 1'b1;
          state_d     = S_HASH;
        end
      end
      S_BLKEND: begin
        if (op_q == OP_INSERT) begin
          if (walked_q < n_q) begin
            state_d = S_ROW;
          end else begin
            fin        = 1'b1;
            fin_status = ST_FULL;
          end
        end else if (walked_q < n_q && seen_q < {1'b0, need_q}) begin
          state_d = S_ROW;
        end else if (op_q == OP_DELETE && found_q) begin
          state_d = S_DEL1;
        end else begin
          fin = 1'b1;
        end
      end
      S_DEL1: begin
        state_d = S_DEL2;
      end
      S_DEL2: begin
        kv_we   = last_ok_q;
        kv_wa   = key_at_q;
        kv_wkey = key_rd_q;
        kv_wval = val_rd_q;
        used_we = 1'b1;
        used_wa = del_idx[IDX_W-1:SLOT_W];
        used_wd = used_rd_q & ~(SLOTS_PER_BLOCK_N'(1) << del_idx[SLOT_W-1:0]);
        cnt_we  = (need_q != '0);
        cnt_wd  = need_q - 1'b1;
        stored_d   = stored_q - 1'b1;
        fin        = 1'b1;
        fin_status = ST_OK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (hit) begin
      if (seen_q == {1'b0, need_q} - 1'b1) begin
        last_at_d = cur_idx;
        last_ok_d = 1'b1;
      end
      seen_d = seen_q + 1'b1;
    end

    if (adv) begin
      if (slot_q == SLOT_LAST) begin
        slot_d   = '0;
        blk_d    = (({1'b0, blk_q} + 1'b1) == n_q) ? '0 : blk_q + 1'b1;
        walked_d = walked_q + 1'b1;
        state_d  = S_BLKEND;
      end else begin
        slot_d  = slot_q + 1'b1;
        state_d = S_SLOT;
      end
    end

    if (fin) begin
      done_d   = 1'b1;
      status_d = fin_status;
      fv_d     = fin_value;
      state_d  = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      blocks_q <= BLOCKS_MAX;
      stored_q <= '0;
      clr_q    <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      fv_q     <= '0;
    end else begin
      state_q  <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        blocks_q <= cfg_data_i;
      end
      stored_q <= stored_d;
      clr_q    <= clr_d;
      done_q   <= done_d;
      status_q <= status_d;
      fv_q     <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    val_q       <= val_d;
    n_q         <= n_d;
    hk_q        <= hk_d;
    h_q         <= h_d;
    rem_q       <= rem_d;
    step_q      <= step_d;
    slot_hash_q <= slot_hash_d;
    home_q      <= home_d;
    need_q      <= need_d;
    seen_q      <= seen_d;
    blk_q       <= blk_d;
    walked_q    <= walked_d;
    slot_q      <= slot_d;
    row_q       <= row_d;
    found_q     <= found_d;
    key_at_q    <= key_at_d;
    last_at_q   <= last_at_d;
    last_ok_q   <= last_ok_d;
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (found_value_o == '0))
    else $error("found value on a failed request");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SLOT) |-> (walked_q < n_q && n_q >= BLOCKS_MIN && n_q <= BLOCKS_MAX))
    else $error("probe past the blocks in use");

  a_del_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEL1) |-> (found_q && op_q == OP_DELETE && stored_q != '0))
    else $error("delete move without a found key");

endmodule

[dv/bucketized_linear_probe_hash_table_tb.sv]
// Testbench for the bucketized linear-probe hash table: directed and random requests
// checked against a built-in table predictor.
`timescale 1ns / 1ps
module bucketized_linear_probe_hash_table_tb;
  import blph_pkg::*;

  localparam int LIMIT_CYCLES = 100000000;
  localparam int POOL_SIZE    = 48;

  typedef struct packed {
    status_e          status;
    logic [VAL_W-1:0] value;
  } answer_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       op_i = OP_FIND;
  logic [KEY_W-1:0] key_i = '0;
  logic [VAL_W-1:0] value_i = '0;
  logic             done_o;
  logic [1:0]       status_o;
  logic [VAL_W-1:0] found_value_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [NB_W-1:0]  cfg_data_i = '0;

  bit               tbl_used [TOTAL_SLOTS];
  logic [KEY_W-1:0] tbl_key  [TOTAL_SLOTS];
  logic [VAL_W-1:0] tbl_val  [TOTAL_SLOTS];
  int unsigned      home_cnt [NUM_BLOCKS];
  int unsigned      pair_cnt;
  logic [NB_W-1:0]  blocks_reg;

  answer_t          pending_answers[$];
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  int               error_cnt;
  longint           cycle_cnt;
  bit               no_gaps;

  bucketized_linear_probe_hash_table i_dut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .key_i, .value_i, .done_o, .status_o,
    .found_value_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned eff_blocks();
    if (blocks_reg < 2) return 2;
    if (blocks_reg > NUM_BLOCKS) return NUM_BLOCKS;
    return blocks_reg;
  endfunction

  function automatic int unsigned hash_home(input logic [KEY_W-1:0] k, input int unsigned n);
    logic [63:0] h;
    h = 64'hcbf29ce484222325;
    for (int b = 0; b < 8; b++) begin
      h = h ^ {56'd0, k[8*b +: 8]};
      h = h * 64'h100000001b3;
    end
    return int'(h % 64'(n));
  endfunction

  function automatic bit chain_lookup(input logic [KEY_W-1:0] k, input int unsigned n,
                                      input bit want_last, output int key_at,
                                      output int last_at, output bit last_ok);
    int unsigned hb, need, seen, blk, idx;
    bit hit;
    hb = hash_home(k, n);
    need = home_cnt[hb];
    seen = 0;
    blk = hb;
    hit = 0;
    last_ok = 0;
    key_at = 0;
    last_at = 0;
    for (int unsigned w = 0; w < n && seen < need; w++) begin
      for (int s = 0; s < SLOTS_PER_BLOCK_N; s++) begin
        idx = blk * SLOTS_PER_BLOCK_N + s;
        if (!tbl_used[idx]) continue;
        if (tbl_key[idx] == k) begin
          hit = 1;
          key_at = idx;
          if (!want_last) return 1;
        end
        if (hash_home(tbl_key[idx], n) == hb) begin
          if (seen == need - 1) begin
            last_at = idx;
            last_ok = 1;
          end
          seen++;
        end
      end
      blk = (blk + 1 == n) ? 0 : blk + 1;
    end
    return hit;
  endfunction

  function automatic answer_t table_request(input op_e op, input logic [KEY_W-1:0] k,
                                            input logic [VAL_W-1:0] v);
    answer_t a;
    int unsigned n, hb, blk, idx;
    int key_at, last_at;
    bit last_ok;
    n = eff_blocks();
    a.status = ST_ABSENT;
    a.value = '0;
    case (op)
      OP_FIND: begin
        if (chain_lookup(k, n, 0, key_at, last_at, last_ok)) begin
          a.status = ST_OK;
          a.value = tbl_val[key_at];
        end
      end
      OP_INSERT: begin
        hb = hash_home(k, n);
        a.status = ST_FULL;
        if (home_cnt[hb] < COUNT_MAX) begin
          blk = hb;
          for (int unsigned w = 0; w < n && a.status == ST_FULL; w++) begin
            for (int s = 0; s < SLOTS_PER_BLOCK_N; s++) begin
              idx = blk * SLOTS_PER_BLOCK_N + s;
              if (tbl_used[idx]) begin
                if (tbl_key[idx] == k) begin
                  a.status = ST_DUP;
                  break;
                end
              end else begin
                tbl_used[idx] = 1;
                tbl_key[idx] = k;
                tbl_val[idx] = v;
                home_cnt[hb]++;
                if (pair_cnt < COUNT_MAX) pair_cnt++;
                a.status = ST_OK;
                break;
              end
            end
            blk = (blk + 1 == n) ? 0 : blk + 1;
          end
        end
      end
      OP_DELETE: begin
        if (pair_cnt != 0 && chain_lookup(k, n, 1, key_at, last_at, last_ok)) begin
          if (last_ok) begin
            tbl_used[last_at] = 0;
            tbl_key[key_at] = tbl_key[last_at];
            tbl_val[key_at] = tbl_val[last_at];
          end else begin
            tbl_used[key_at] = 0;
          end
          hb = hash_home(k, n);
          if (home_cnt[hb] > 0) home_cnt[hb]--;
          pair_cnt--;
          a.status = ST_OK;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic send_request(input op_e op, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] v);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    op_i = op;
    key_i = k;
    value_i = v;
    do @(posedge clk_i); while (busy);
    pending_answers.push_back(table_request(op, k, v));
    @(negedge clk_i);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_blocks(input logic [NB_W-1:0] n);
    drain();
    cfg_valid_i = 1'b1;
    cfg_data_i = n;
    do @(posedge clk_i); while (!cfg_ready_o);
    blocks_reg = n;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_request();
    int sel;
    op_e op;
    logic [KEY_W-1:0] k;
    sel = $urandom_range(0, 99);
    op = sel < 35 ? OP_INSERT : sel < 70 ? OP_FIND : sel < 95 ? OP_DELETE : OP_NONE;
    k = $urandom_range(0, 99) < 85 ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                   : {$urandom, $urandom};
    send_request(op, k, {$urandom, $urandom});
  endtask

  task automatic test_directed();
    send_request(OP_DELETE, 64'd5, '0);
    send_request(OP_FIND, '0, '1);
    send_request(OP_INSERT, '0, '1);
    send_request(OP_INSERT, '1, '0);
    send_request(OP_INSERT, '0, 64'h1234);
    send_request(OP_FIND, '0, '0);
    send_request(OP_FIND, '1, '1);
    send_request(OP_NONE, '1, '1);
    send_request(OP_FIND, 64'hdead_beef, '0);
    send_request(OP_DELETE, '0, '0);
    send_request(OP_FIND, '0, '0);
    send_request(OP_DELETE, '1, '0);
    send_request(OP_DELETE, '1, '0);
  endtask

  task automatic test_full_table();
    write_blocks(NB_W'(1));
    for (int i = 0; i < 10; i++) send_request(OP_INSERT, key_pool[i], {$urandom, $urandom});
    for (int i = 0; i < 10; i++) send_request(OP_FIND, key_pool[i], '0);
    for (int i = 0; i < 6; i++) send_request(OP_DELETE, key_pool[i], '0);
  endtask

  task automatic test_random_phases();
    logic [NB_W-1:0] sizes[10] = '{256, 2, 0, 3, 17, 511, 64, 1, 255, 256};
    foreach (sizes[p]) begin
      write_blocks(sizes[p]);
      no_gaps = (p % 3 == 1);
      repeat (72) random_request();
      no_gaps = 0;
    end
  endtask

  always @(posedge clk_i) begin
    answer_t want;
    if (done_o) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: result with none expected: status %0d value %h",
                 $time, status_o, found_value_o);
        error_cnt++;
      end else begin
        want = pending_answers.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          error_cnt++;
        end
        if (found_value_o !== want.value) begin
          $display("%0t: found_value expected %h actual %h", $time, want.value,
                   found_value_o);
          error_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    blocks_reg = NB_W'(NUM_BLOCKS);
    pair_cnt = 0;
    foreach (tbl_used[i]) tbl_used[i] = 0;
    foreach (home_cnt[i]) home_cnt[i] = 0;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_full_table();
    test_random_phases();
    drain();
    repeat (200) @(posedge clk_i);
    if (error_cnt == 0 && pending_answers.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
